/* hw/rtl/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, held off while arst_n is low
`define ASSERT_CLK_RST(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// concurrent check on clk, also active during reset
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/bcc_pkg.sv */
// types and constants of the button click classifier
`timescale 1ns / 1ps

package bcc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_ACTIVE_LEVEL   = 3'd0;
	localparam logic [2:0] REG_MODE           = 3'd1;
	localparam logic [2:0] REG_REPEAT_ENABLE  = 3'd2;
	localparam logic [2:0] REG_DEBOUNCE_MS    = 3'd3;
	localparam logic [2:0] REG_LONG_MIN_MS    = 3'd4;
	localparam logic [2:0] REG_REPEAT_MS      = 3'd5;
	localparam logic [2:0] REG_GAP_MS         = 3'd6;
	localparam logic [2:0] REG_REPRESS_MIN_MS = 3'd7;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// mode codes; the unused code behaves as click mode
	localparam logic [1:0] MODE_FAST   = 2'd0;
	localparam logic [1:0] MODE_CLICK  = 2'd1;
	localparam logic [1:0] MODE_DOUBLE = 2'd2;

	// reset values of the registers
	localparam logic        RST_ACTIVE_LEVEL   = 1'b0;
	localparam logic [1:0]  RST_MODE           = MODE_CLICK;
	localparam logic        RST_REPEAT_ENABLE  = 1'b0;
	localparam logic [7:0]  RST_DEBOUNCE_MS    = 8'd50;
	localparam logic [15:0] RST_LONG_MIN_MS    = 16'd1000;
	localparam logic [15:0] RST_REPEAT_MS      = 16'd500;
	localparam logic [9:0]  RST_GAP_MS         = 10'd250;
	localparam logic [7:0]  RST_REPRESS_MIN_MS = 8'd20;

	// clicks that close a sequence in double mode
	localparam logic [3:0] DOUBLE_CLICKS = 4'd2;
	localparam logic [3:0] CLICKS_MAX    = 4'd15;
	localparam logic [9:0] RELEASE_MAX   = 10'h3FF;

	// configuration seen by the classifier
	typedef struct packed {
		logic        active_level;
		logic [1:0]  mode;
		logic        repeat_enable;
		logic [7:0]  debounce_ms;
		logic [15:0] long_min_ms;
		logic [15:0] repeat_ms;
		logic [9:0]  gap_ms;
		logic [7:0]  repress_min_ms;
	} cfg_t;

endpackage

/* hw/rtl/bcc_cfg.sv */
// configuration register file of the button click classifier
`timescale 1ns / 1ps

module bcc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [bcc_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [bcc_pkg::CFG_DATA_W-1:0]   wr_data,
	output bcc_pkg::cfg_t                    cfg
);
	import bcc_pkg::*;

	cfg_t cfg_q;

	// register writes, one field per index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level   <= RST_ACTIVE_LEVEL;
			cfg_q.mode           <= RST_MODE;
			cfg_q.repeat_enable  <= RST_REPEAT_ENABLE;
			cfg_q.debounce_ms    <= RST_DEBOUNCE_MS;
			cfg_q.long_min_ms    <= RST_LONG_MIN_MS;
			cfg_q.repeat_ms      <= RST_REPEAT_MS;
			cfg_q.gap_ms         <= RST_GAP_MS;
			cfg_q.repress_min_ms <= RST_REPRESS_MIN_MS;
		end else if (wr_en) begin
			case (wr_index)
				REG_ACTIVE_LEVEL:   cfg_q.active_level   <= wr_data[0];
				REG_MODE:           cfg_q.mode           <= wr_data[1:0];
				REG_REPEAT_ENABLE:  cfg_q.repeat_enable  <= wr_data[0];
				REG_DEBOUNCE_MS:    cfg_q.debounce_ms    <= wr_data[7:0];
				REG_LONG_MIN_MS:    cfg_q.long_min_ms    <= wr_data[15:0];
				REG_REPEAT_MS:      cfg_q.repeat_ms      <= wr_data[15:0];
				REG_GAP_MS:         cfg_q.gap_ms         <= wr_data[9:0];
				REG_REPRESS_MIN_MS: cfg_q.repress_min_ms <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/button_click_classifier.sv */
// top level of the button click classifier
// a sample is taken into the input register, and its result then into the result register
// throughput: one sample per cycle while the result side is not stalled
// the input register and the phase and counter update set the per-sample cost
// reset: arst_n clears phase, counters and the valid bits of both registers, and loads register defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"

module button_click_classifier #(
	parameter int TIME_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             level,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [3:0]                       click_count,
	output logic                             is_long,
	output logic [15:0]                      long_time,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bcc_pkg::*;

	localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;
	localparam logic [TIME_BITS-1:0] PRESS_MAX = {TIME_BITS{1'b1}};

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_PRESS   = 4'b0010,
		PH_GAP     = 4'b0100,
		PH_REPRESS = 4'b1000
	} phase_t;

	cfg_t cfg;

	phase_t                phase_q, phase_d;
	logic [TIME_BITS-1:0]  press_q, press_d, press_inc;
	logic [9:0]            release_q, release_d, release_inc;
	logic [3:0]            clicks_q, clicks_d, clicks_add;

	logic                  valid_s1, level_s1;
	logic                  advance;
	logic                  pressed, fast, double_mode;
	logic [15:0]           rep_thr;
	logic [CMP_W-1:0]      press_ext, press_inc_ext;
	logic [15:0]           press_sat;

	logic                  emit;
	logic [3:0]            emit_clicks;
	logic                  emit_long;
	logic [15:0]           emit_time;

	logic                  out_valid_q;
	logic [3:0]            click_count_q;
	logic                  is_long_q;
	logic [15:0]           long_time_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	bcc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// handshake: the sample stage moves when the result register can take a result
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= level;
		end
	end

	// decoded settings and saturating increments
	assign pressed     = (level_s1 == cfg.active_level);
	assign fast        = (cfg.mode == MODE_FAST);
	assign double_mode = (cfg.mode == MODE_DOUBLE);
	assign rep_thr     = (cfg.repeat_ms < {8'd0, cfg.debounce_ms}) ?
		{8'd0, cfg.debounce_ms} : cfg.repeat_ms;

	assign press_inc     = (press_q == PRESS_MAX) ? press_q : press_q + TIME_BITS'(1);
	assign release_inc   = (release_q == RELEASE_MAX) ? release_q : release_q + 10'd1;
	assign press_ext     = CMP_W'(press_q);
	assign press_inc_ext = CMP_W'(press_inc);
	assign press_sat     = (press_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF : press_ext[15:0];

	// click added by a finished re-press, saturating
	assign clicks_add = ((press_ext > CMP_W'(cfg.repress_min_ms)) && (clicks_q != CLICKS_MAX)) ?
		clicks_q + 4'd1 : clicks_q;

	// next state and result for the sample in the input register
	always_comb begin
		phase_d     = phase_q;
		press_d     = press_q;
		release_d   = release_q;
		clicks_d    = clicks_q;
		emit        = 1'b0;
		emit_clicks = 4'd1;
		emit_long   = 1'b0;
		emit_time   = 16'd0;
		case (phase_q)
			PH_IDLE, PH_PRESS: begin
				if (pressed) begin
					phase_d = PH_PRESS;
					press_d = press_inc;
					// repeated click while held in fast mode
					if (fast && cfg.repeat_enable && (press_inc_ext >= CMP_W'(rep_thr))) begin
						press_d = '0;
						emit    = (press_inc_ext > CMP_W'(cfg.debounce_ms));
					end
				end else if (phase_q == PH_PRESS) begin
					press_d = '0;
					phase_d = PH_IDLE;
					if (press_ext > CMP_W'(cfg.debounce_ms)) begin
						if (fast) begin
							emit = 1'b1;
						end else if (press_ext >= CMP_W'(cfg.long_min_ms)) begin
							emit      = 1'b1;
							emit_long = 1'b1;
							emit_time = press_sat;
						end else begin
							// first click opens a sequence; release sample is its first gap tick
							release_d = 10'd1;
							if (cfg.gap_ms <= 10'd1) begin
								emit     = 1'b1;
								clicks_d = '0;
							end else begin
								clicks_d = 4'd1;
								phase_d  = PH_GAP;
							end
						end
					end
				end
			end
			PH_GAP: begin
				if (pressed) begin
					phase_d   = PH_REPRESS;
					press_d   = TIME_BITS'(1);
					release_d = '0;
				end else begin
					release_d = release_inc;
					if (release_inc >= cfg.gap_ms) begin
						emit        = 1'b1;
						emit_clicks = clicks_q;
						phase_d     = PH_IDLE;
						clicks_d    = '0;
						release_d   = '0;
					end
				end
			end
			PH_REPRESS: begin
				if (pressed) begin
					press_d = press_inc;
				end else begin
					press_d     = '0;
					emit_clicks = clicks_add;
					if (double_mode && (clicks_add == DOUBLE_CLICKS)) begin
						emit     = 1'b1;
						phase_d  = PH_IDLE;
						clicks_d = '0;
					end else begin
						release_d = 10'd1;
						if (cfg.gap_ms <= 10'd1) begin
							emit     = 1'b1;
							phase_d  = PH_IDLE;
							clicks_d = '0;
						end else begin
							clicks_d = clicks_add;
							phase_d  = PH_GAP;
						end
					end
				end
			end
			default: begin
				phase_d   = PH_IDLE;
				press_d   = '0;
				release_d = '0;
				clicks_d  = '0;
			end
		endcase
	end

	// classifier state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			press_q   <= '0;
			release_q <= '0;
			clicks_q  <= '0;
		end else if (valid_s1 && advance) begin
			phase_q   <= phase_d;
			press_q   <= press_d;
			release_q <= release_d;
			clicks_q  <= clicks_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			click_count_q <= emit_clicks;
			is_long_q     <= emit_long;
			long_time_q   <= emit_time;
		end
	end

	assign out_valid   = out_valid_q;
	assign click_count = click_count_q;
	assign is_long     = is_long_q;
	assign long_time   = long_time_q;

	// checks
	`ASSERT_CLK_RST(a_long_single, out_valid_q && is_long_q |-> click_count_q == 4'd1,
		"long click must carry one click")
	`ASSERT_CLK_RST(a_time_only_long, out_valid_q && !is_long_q |-> long_time_q == 16'd0,
		"duration set on a non-long event")
	`ASSERT_CLK_RST(a_idle_no_clicks, phase_q == PH_IDLE |-> clicks_q == 4'd0,
		"clicks left over in idle")
	`ASSERT_CLK_RST(a_gap_has_clicks, phase_q == PH_GAP |-> clicks_q != 4'd0,
		"gap phase without a click")

endmodule

/* test/button_click_classifier_test.sv */
// testbench of the button click classifier: directed and random streams against a predictor
`timescale 1ns / 1ps

module button_click_classifier_test;
	import bcc_pkg::*;

	localparam int PIPE_LAT       = 1;
	localparam int SETTLE_CYCLES  = PIPE_LAT + 6;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_SAMPLES = 700;
	localparam logic [15:0] TIME_MAX = 16'hFFFF;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef enum logic [1:0] {PH_IDLE, PH_PRESS, PH_GAP, PH_REPRESS} press_phase_t;

	typedef struct packed {
		logic [3:0]  click_count;
		logic        is_long;
		logic [15:0] long_time;
	} click_event_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   in_valid    = 1'b0;
	logic                   in_ready;
	logic                   level       = 1'b0;
	logic                   out_valid;
	logic                   out_ready   = 1'b0;
	logic [3:0]             click_count;
	logic                   is_long;
	logic [15:0]            long_time;
	logic                   cfg_valid   = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;

	// predictor state and its copy of the registers
	cfg_t         model_cfg;
	press_phase_t model_phase;
	logic [15:0]  model_press;
	logic [9:0]   model_release;
	logic [3:0]   model_clicks;

	click_event_t expected_events[$];
	click_event_t exp_ev;
	int           errors       = 0;
	int           samples_sent = 0;
	int           idle_cnt     = 0;
	int           stall_left   = 0;
	bit           quiet        = 1'b0;

	button_click_classifier #(
		.TIME_BITS(16)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.level      (level),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.click_count(click_count),
		.is_long    (is_long),
		.long_time  (long_time),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly short, a few long
	function automatic int idle_len();
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------- predictor ----------------

	task automatic push_event(input logic [3:0] cnt, input logic lng, input logic [15:0] dur);
		click_event_t ev;
		ev.click_count = cnt;
		ev.is_long     = lng;
		ev.long_time   = dur;
		expected_events.push_back(ev);
	endtask

	// first released tick of a gap; a gap limit of zero or one closes at once
	task automatic open_gap();
		model_release = 10'd1;
		model_phase   = PH_GAP;
		if (model_release >= model_cfg.gap_ms) begin
			push_event(model_clicks, 1'b0, 16'd0);
			model_phase  = PH_IDLE;
			model_clicks = 4'd0;
		end
	endtask

	task automatic classify_sample(input logic lvl);
		logic        pressed;
		logic        fast;
		logic [15:0] rep_thr;
		logic [15:0] held;
		pressed = (lvl == model_cfg.active_level);
		fast    = (model_cfg.mode == MODE_FAST);
		rep_thr = (model_cfg.repeat_ms < {8'd0, model_cfg.debounce_ms}) ?
			{8'd0, model_cfg.debounce_ms} : model_cfg.repeat_ms;
		case (model_phase)
			PH_IDLE, PH_PRESS: begin
				if (pressed) begin
					model_phase = PH_PRESS;
					if (model_press != TIME_MAX)
						model_press = model_press + 16'd1;
					// held repeat in fast mode
					if (fast && model_cfg.repeat_enable && model_press >= rep_thr) begin
						held        = model_press;
						model_press = 16'd0;
						if (held > {8'd0, model_cfg.debounce_ms})
							push_event(4'd1, 1'b0, 16'd0);
					end
				end else if (model_phase == PH_PRESS) begin
					held        = model_press;
					model_press = 16'd0;
					model_phase = PH_IDLE;
					if (held > {8'd0, model_cfg.debounce_ms}) begin
						if (fast)
							push_event(4'd1, 1'b0, 16'd0);
						else if (held >= model_cfg.long_min_ms)
							push_event(4'd1, 1'b1, held);
						else begin
							model_clicks = 4'd1;
							open_gap();
						end
					end
				end
			end
			PH_GAP: begin
				if (pressed) begin
					model_phase   = PH_REPRESS;
					model_press   = 16'd1;
					model_release = 10'd0;
				end else begin
					if (model_release != RELEASE_MAX)
						model_release = model_release + 10'd1;
					if (model_release >= model_cfg.gap_ms) begin
						push_event(model_clicks, 1'b0, 16'd0);
						model_phase   = PH_IDLE;
						model_clicks  = 4'd0;
						model_release = 10'd0;
					end
				end
			end
			default: begin
				if (pressed) begin
					if (model_press != TIME_MAX)
						model_press = model_press + 16'd1;
				end else begin
					if (model_press > {8'd0, model_cfg.repress_min_ms} &&
						model_clicks != CLICKS_MAX)
						model_clicks = model_clicks + 4'd1;
					model_press = 16'd0;
					// double mode closes on its second click
					if (model_cfg.mode == MODE_DOUBLE && model_clicks == DOUBLE_CLICKS) begin
						push_event(model_clicks, 1'b0, 16'd0);
						model_phase  = PH_IDLE;
						model_clicks = 4'd0;
					end else
						open_gap();
				end
			end
		endcase
	endtask

	task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ACTIVE_LEVEL:   model_cfg.active_level   = data[0];
			REG_MODE:           model_cfg.mode           = data[1:0];
			REG_REPEAT_ENABLE:  model_cfg.repeat_enable  = data[0];
			REG_DEBOUNCE_MS:    model_cfg.debounce_ms    = data[7:0];
			REG_LONG_MIN_MS:    model_cfg.long_min_ms    = data;
			REG_REPEAT_MS:      model_cfg.repeat_ms      = data;
			REG_GAP_MS:         model_cfg.gap_ms         = data[9:0];
			REG_REPRESS_MIN_MS: model_cfg.repress_min_ms = data[7:0];
			default: ;
		endcase
	endtask

	// ---------------- drivers ----------------

	task automatic send_sample(input logic lvl);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 99) < 25) begin
			in_valid = 1'b0;
			repeat (idle_len()) @(negedge clk);
		end
		in_valid = 1'b1;
		level    = lvl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		classify_sample(lvl);
		samples_sent++;
	endtask

	task automatic hold(input logic lvl, input int n);
		repeat (n) send_sample(lvl);
	endtask

	task automatic hold_off();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_results();
		while (expected_events.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, data);
	endtask

	// registers change only with the block drained and settled
	task automatic load_config(input logic al, input logic [1:0] md, input logic rep,
		input logic [7:0] deb, input logic [15:0] lmin, input logic [15:0] rms,
		input logic [9:0] gap, input logic [7:0] rmin);
		hold_off();
		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(REG_ACTIVE_LEVEL, {15'd0, al});
		write_reg(REG_MODE, {14'd0, md});
		write_reg(REG_REPEAT_ENABLE, {15'd0, rep});
		write_reg(REG_DEBOUNCE_MS, {8'd0, deb});
		write_reg(REG_LONG_MIN_MS, lmin);
		write_reg(REG_REPEAT_MS, rms);
		write_reg(REG_GAP_MS, {6'd0, gap});
		write_reg(REG_REPRESS_MIN_MS, {8'd0, rmin});
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// result side stalls
	always @(negedge clk) begin
		if (quiet) begin
			stall_left = 0;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 15) begin
			stall_left = idle_len() - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	// ---------------- checker ----------------

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual %0d/%0d/%0d",
					$time, click_count, is_long, long_time);
			end else begin
				exp_ev = expected_events.pop_front();
				if (click_count !== exp_ev.click_count) begin
					errors++;
					$display("%0t click_count mismatch: expected %0d, actual %0d",
						$time, exp_ev.click_count, click_count);
				end
				if (is_long !== exp_ev.is_long) begin
					errors++;
					$display("%0t is_long mismatch: expected %0d, actual %0d",
						$time, exp_ev.is_long, is_long);
				end
				if (long_time !== exp_ev.long_time) begin
					errors++;
					$display("%0t long_time mismatch: expected %0d, actual %0d",
						$time, exp_ev.long_time, long_time);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready))
			idle_cnt = 0;
		else
			idle_cnt = idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------- tests ----------------

	// register defaults: pressed is level 0, debounce 50, gap 250
	task automatic test_reset_defaults();
		hold(1'b0, 50);
		hold(1'b1, 1);
		hold(1'b0, 60);
		hold(1'b1, 30);
		hold(1'b0, 30);
		hold(1'b1, 250);
	endtask

	task automatic test_special_cases();
		// fast click, then a press that stays at debounce
		load_config(1'b1, MODE_FAST, 1'b0, 8'd2, 16'd6, 16'd4, 10'd3, 8'd1);
		hold(1'b1, 3);
		hold(1'b0, 2);
		hold(1'b1, 2);
		hold(1'b0, 1);
		// repeat interval below debounce falls back to debounce, never clicks
		load_config(1'b1, MODE_FAST, 1'b1, 8'd2, 16'd6, 16'd0, 10'd3, 8'd1);
		hold(1'b1, 7);
		hold(1'b0, 1);
		// repeat every four ticks while held
		load_config(1'b1, MODE_FAST, 1'b1, 8'd2, 16'd6, 16'd4, 10'd3, 8'd1);
		hold(1'b1, 9);
		hold(1'b0, 1);
		// unused mode acts as click mode with repeat ignored
		load_config(1'b1, MODE_UNUSED, 1'b1, 8'd2, 16'd6, 16'd4, 10'd3, 8'd1);
		hold(1'b1, 7);
		hold(1'b0, 1);
		// double mode: closes on second click, single click closes by gap
		load_config(1'b0, MODE_DOUBLE, 1'b0, 8'd2, 16'd6, 16'd4, 10'd3, 8'd1);
		hold(1'b0, 3);
		hold(1'b1, 1);
		hold(1'b0, 3);
		hold(1'b1, 1);
		hold(1'b0, 3);
		hold(1'b1, 3);
		// zero gap closes on the release sample
		load_config(1'b0, MODE_CLICK, 1'b0, 8'd2, 16'd6, 16'd4, 10'd0, 8'd1);
		hold(1'b0, 3);
		hold(1'b1, 1);
		// re-press too short to add a click
		load_config(1'b0, MODE_CLICK, 1'b0, 8'd2, 16'd6, 16'd4, 10'd3, 8'd255);
		hold(1'b0, 3);
		hold(1'b1, 1);
		hold(1'b0, 5);
		hold(1'b1, 3);
		// long minimum of zero makes every counted press long
		load_config(1'b0, MODE_CLICK, 1'b0, 8'd2, 16'd0, 16'd4, 10'd3, 8'd1);
		hold(1'b0, 3);
		hold(1'b1, 1);
	endtask

	task automatic test_click_saturation();
		load_config(1'b1, MODE_CLICK, 1'b0, 8'd0, 16'd100, 16'd4, 10'd2, 8'd0);
		hold(1'b1, 1);
		repeat (17) begin
			hold(1'b0, 1);
			hold(1'b1, 1);
		end
		hold(1'b0, 2);
	endtask

	// thresholds at the top of the debounce range: held repeat and a long click
	task automatic test_counter_limits();
		quiet = 1'b1;
		load_config(1'b0, MODE_FAST, 1'b1, 8'd255, 16'hFFFF, 16'd260, 10'd3, 8'd1);
		hold(1'b0, 262);
		hold(1'b1, 1);
		load_config(1'b0, MODE_CLICK, 1'b0, 8'd255, 16'd256, 16'd4, 10'd3, 8'd1);
		hold(1'b0, 300);
		hold(1'b1, 1);
		quiet = 1'b0;
	endtask

	// press length near a threshold, or anywhere up to twice it plus four; above 300, a short press of 1 to 30
	function automatic int press_len(input int thr);
		int d;
		if (thr > 300)
			return $urandom_range(1, 30);
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(1, 2 * thr + 4);
		d = $urandom_range(0, 4);
		d = thr + d - 2;
		return (d < 1) ? 1 : d;
	endfunction

	task automatic send_sequence();
		logic act;
		int   deb;
		int   lmin;
		int   rep_thr;
		int   gap;
		int   rmin;
		int   n_rep;
		act     = model_cfg.active_level;
		deb     = int'(model_cfg.debounce_ms);
		lmin    = int'(model_cfg.long_min_ms);
		rep_thr = int'(model_cfg.repeat_ms);
		gap     = int'(model_cfg.gap_ms);
		rmin    = int'(model_cfg.repress_min_ms);
		if (rep_thr < deb)
			rep_thr = deb;
		// opening press near one of the thresholds, or a short one of 1 to 12
		case ($urandom_range(0, 3))
			0: hold(act, press_len(deb + 1));
			1: hold(act, press_len(lmin));
			2: hold(act, press_len(rep_thr * $urandom_range(1, 3)));
			default: hold(act, $urandom_range(1, 12));
		endcase
		// re-presses inside the gap, sometimes enough to saturate the count
		n_rep = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 3);
		repeat (n_rep) begin
			hold(~act, (gap > 1) ? $urandom_range(1, gap - 1) : 1);
			hold(act, press_len(rmin + 1));
		end
		// closing release, now and then cut short
		if ($urandom_range(0, 7) == 0)
			hold(~act, (gap > 1) ? $urandom_range(1, gap - 1) : 1);
		else
			hold(~act, gap + 1 + $urandom_range(0, 2));
	endtask

	task automatic test_random();
		int          target;
		int          seq;
		logic [7:0]  deb;
		logic [15:0] lmin;
		logic [15:0] rms;
		logic [9:0]  gap;
		logic [7:0]  rmin;
		target = samples_sent + RANDOM_SAMPLES;
		while (samples_sent < target) begin
			// new register set, extremes now and then
			case ($urandom_range(0, 9))
				0: deb = 8'd0;
				1: deb = (($urandom_range(0, 2) == 0) ? 8'd255 : 8'd0);
				default: deb = 8'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 9))
				0: lmin = 16'd0;
				1: lmin = 16'hFFFF;
				default: lmin = {8'd0, deb} + 16'($urandom_range(1, 30));
			endcase
			case ($urandom_range(0, 9))
				0: rms = 16'd0;
				1: rms = 16'hFFFF;
				default: rms = 16'($urandom_range(1, 20));
			endcase
			case ($urandom_range(0, 9))
				0: gap = 10'd0;
				1: gap = 10'd1;
				default: gap = 10'($urandom_range(2, 25));
			endcase
			case ($urandom_range(0, 9))
				0: rmin = 8'd0;
				1: rmin = 8'd255;
				default: rmin = 8'($urandom_range(1, 8));
			endcase
			quiet = 1'b0;
			load_config(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), deb, lmin, rms, gap, rmin);
			for (seq = 0; seq < 6 && samples_sent < target; seq++) begin
				quiet = ($urandom_range(0, 5) == 0);
				if ($urandom_range(0, 6) == 0)
					repeat ($urandom_range(4, 16)) send_sample(1'($urandom_range(0, 1)));
				else
					send_sequence();
				// sender holds off until every result is in
				if (seq == 2) begin
					hold_off();
					wait_results();
				end
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		model_cfg.active_level   = RST_ACTIVE_LEVEL;
		model_cfg.mode           = RST_MODE;
		model_cfg.repeat_enable  = RST_REPEAT_ENABLE;
		model_cfg.debounce_ms    = RST_DEBOUNCE_MS;
		model_cfg.long_min_ms    = RST_LONG_MIN_MS;
		model_cfg.repeat_ms      = RST_REPEAT_MS;
		model_cfg.gap_ms         = RST_GAP_MS;
		model_cfg.repress_min_ms = RST_REPRESS_MIN_MS;
		model_phase   = PH_IDLE;
		model_press   = 16'd0;
		model_release = 10'd0;
		model_clicks  = 4'd0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_special_cases();
		test_click_saturation();
		test_counter_limits();
		test_random();

		hold_off();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
